/* rtl/core/dpd_pkg.sv */
// Shared types, widths and codes for the duplicate-checking priority deque.
package dpd_pkg;

  // Sizing
  localparam int NUM_QUEUES  = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int SLOTS       = NUM_QUEUES * QUEUE_DEPTH;

  localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int HW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int PSUM_W = HW + 1;
  localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int QSEL_W  = 2;
  localparam int KEY_W   = 40;
  localparam int AGE_W   = 8;
  localparam int BLOOD_W = 3;
  localparam int STAT_W  = 2;
  localparam int REC_W   = KEY_W + AGE_W + 1 + BLOOD_W;
  localparam int TDATA_W = ((REC_W + 7) / 8) * 8;
  localparam int TUSER_W = CMD_W + QSEL_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_URGENT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  // Commit actions taken when the result is loaded
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_ADD  = 2'd1;
  localparam logic [1:0] ACT_POP  = 2'd2;

  // One stored record, key in the low bits
  typedef struct packed {
    logic [BLOOD_W-1:0] blood;
    logic               gender;
    logic [AGE_W-1:0]   age;
    logic [KEY_W-1:0]   key;
  } rec_t;

  // Controller to datapath
  typedef struct packed {
    logic              load_req;
    logic              scan_en;
    logic              pop_rd;
    logic              out_load;
    logic [STAT_W-1:0] res_status;
    logic [1:0]        res_act;
  } dpd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bad_req;
    logic is_pop;
    logic key_zero;
    logic empty;
    logic full;
    logic scan_done;
    logic dup;
    logic out_free;
  } dpd_stat_t;

  // Fold a position sum back into the circular range
  function automatic logic [HW-1:0] wrap_pos(input logic [PSUM_W-1:0] s);
    if (s >= PSUM_W'(QUEUE_DEPTH)) begin
      wrap_pos = HW'(s - PSUM_W'(QUEUE_DEPTH));
    end else begin
      wrap_pos = HW'(s);
    end
  endfunction

  // Flat memory address of a queue position
  function automatic logic [AW-1:0] slot_addr(input logic [QW-1:0] q,
                                              input logic [HW-1:0] pos);
    slot_addr = AW'(32'(q) * QUEUE_DEPTH + 32'(pos));
  endfunction

endpackage

/* rtl/core/dedup_priority_deque.sv */
// Top level of the duplicate-checking priority deque.
// NUM_QUEUES independent queues of up to QUEUE_DEPTH records each share one
// record memory. A request appends at the tail, inserts at the head, or pops
// the head; every request gives exactly one result with a status. An add first
// walks the addressed queue's stored keys through the memory read port, one
// key per cycle, and checks each against the new key. The next request is
// accepted while a finished result still waits on the output register; a
// request whose result is ready while the previous one is still untaken holds
// until that one is taken. No clearing pass follows reset.
module dedup_priority_deque import dpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // record_key, record_age, record_gender, record_blood, zero pad
  input  logic [TDATA_W-1:0] s_tdata,
  // command, queue_select
  input  logic [TUSER_W-1:0] s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  // out_key, out_age, out_gender, out_blood, zero pad
  output logic [TDATA_W-1:0] m_tdata,
  // status
  output logic [STAT_W-1:0]  m_tuser
);

  dpd_cmd_t  cmd;
  dpd_stat_t stat;

  // Sequencer
  dpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and result path
  dpd_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

/* rtl/core/dpd_ctrl.sv */
// Request sequencer: accept, classify, scan for duplicates, commit and deliver.
module dpd_ctrl import dpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  dpd_stat_t stat,
  output dpd_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_POP_RD = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]        state, state_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  logic [1:0]        res_act, res_act_next;

  // Next-state and command decode
  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_act_next    = res_act;
    s_tready        = 1'b0;
    cmd             = '0;
    cmd.res_status  = res_status;
    cmd.res_act     = res_act;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        res_act_next = ACT_NONE;
        if (stat.bad_req) begin
          res_status_next = ST_REJECT;
          state_next      = S_RESULT;
        end else if (stat.is_pop) begin
          if (stat.empty) begin
            res_status_next = ST_EMPTY;
            state_next      = S_RESULT;
          end else begin
            state_next = S_POP_RD;
          end
        end else if (stat.key_zero) begin
          res_status_next = ST_REJECT;
          state_next      = S_RESULT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_done) begin
          state_next = S_RESULT;
          if (stat.dup) begin
            res_status_next = ST_REJECT;
          end else if (stat.full) begin
            res_status_next = ST_FULL;
          end else begin
            res_status_next = ST_OK;
            res_act_next    = ACT_ADD;
          end
        end
      end
      S_POP_RD: begin
        cmd.pop_rd      = 1'b1;
        res_status_next = ST_OK;
        res_act_next    = ACT_POP;
        state_next      = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_OK;
      res_act    <= ACT_NONE;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_act    <= res_act_next;
    end
  end

endmodule

/* rtl/core/dpd_datapath.sv */
// Record memory, per-queue head and fill registers, key scan and result register.
module dpd_datapath import dpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [TDATA_W-1:0] s_tdata,
  input  logic [TUSER_W-1:0] s_tuser,
  input  dpd_cmd_t           cmd,
  output dpd_stat_t          stat,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic [STAT_W-1:0]  m_tuser
);

  rec_t mem [SLOTS];

  logic [CMD_W-1:0]  req_cmd;
  logic [QSEL_W-1:0] req_q;
  rec_t              req_rec;

  logic [HW-1:0] head [NUM_QUEUES];
  logic [CW-1:0] fill [NUM_QUEUES];

  logic [CW-1:0] scan_idx;
  logic          rd_valid;
  logic          dup;
  rec_t          rd_data;
  rec_t          out_rec;
  logic [STAT_W-1:0] out_status;

  logic [QW-1:0]     qi;
  logic [HW-1:0]     cur_head;
  logic [CW-1:0]     cur_fill;
  logic              scan_more;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [HW-1:0]     wr_pos;
  logic [AW-1:0]     wr_addr;
  logic              commit_pop;
  logic              out_free;

  // Addressed queue and its pointers
  always_comb begin
    qi        = QW'(req_q);
    cur_head  = head[qi];
    cur_fill  = fill[qi];
    scan_more = (scan_idx < cur_fill);
    out_free  = !m_tvalid || m_tready;
  end

  // Read and write addresses
  always_comb begin
    rd_en   = (cmd.scan_en && scan_more) || cmd.pop_rd;
    rd_addr = slot_addr(qi, wrap_pos(PSUM_W'(cur_head) + PSUM_W'(scan_idx)));
    wr_en   = cmd.out_load && (cmd.res_act == ACT_ADD);
    commit_pop = cmd.out_load && (cmd.res_act == ACT_POP);
    if (req_cmd == CMD_URGENT) begin
      wr_pos = (cur_head == '0) ? HW'(QUEUE_DEPTH - 1) : cur_head - HW'(1);
    end else begin
      wr_pos = wrap_pos(PSUM_W'(cur_head) + PSUM_W'(cur_fill));
    end
    wr_addr = slot_addr(qi, wr_pos);
  end

  // Status toward the controller
  always_comb begin
    stat.bad_req   = (32'(req_q) >= NUM_QUEUES) || (req_cmd == CMD_UNUSED);
    stat.is_pop    = (req_cmd == CMD_POP);
    stat.key_zero  = (req_rec.key == '0);
    stat.empty     = (cur_fill == '0);
    stat.full      = (cur_fill >= CW'(QUEUE_DEPTH));
    stat.scan_done = !scan_more && !rd_valid;
    stat.dup       = dup;
    stat.out_free  = out_free;
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_cmd <= CMD_APPEND;
      req_q   <= '0;
    end else if (cmd.load_req) begin
      req_cmd <= s_tuser[CMD_W-1:0];
      req_q   <= s_tuser[CMD_W +: QSEL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_rec <= rec_t'(s_tdata[REC_W-1:0]);
    end
  end

  // Walk the stored keys, one read per cycle, compare in the cycle after each read
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_valid <= 1'b0;
      dup      <= 1'b0;
    end else if (cmd.load_req) begin
      scan_idx <= '0;
      rd_valid <= 1'b0;
      dup      <= 1'b0;
    end else if (cmd.scan_en) begin
      rd_valid <= scan_more;
      if (scan_more) begin
        scan_idx <= scan_idx + CW'(1);
      end
      if (rd_valid && (rd_data.key == req_rec.key)) begin
        dup <= 1'b1;
      end
    end
  end

  // Record memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req_rec;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Advance head and fill on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else if (wr_en) begin
      fill[qi] <= cur_fill + CW'(1);
      if (req_cmd == CMD_URGENT) begin
        head[qi] <= wr_pos;
      end
    end else if (commit_pop) begin
      fill[qi] <= cur_fill - CW'(1);
      head[qi] <= wrap_pos(PSUM_W'(cur_head) + PSUM_W'(1));
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.res_status;
      out_rec    <= (cmd.res_act == ACT_POP) ? rd_data : '0;
    end
  end

  assign m_tdata = TDATA_W'(out_rec);
  assign m_tuser = out_status;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    cur_fill <= CW'(QUEUE_DEPTH))
    else $error("fill count above queue depth");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result loaded over an untaken result");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    commit_pop |-> (cur_fill != '0))
    else $error("pop committed on an empty queue");
  a_add_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((cur_fill < CW'(QUEUE_DEPTH)) && !dup && (req_rec.key != '0)))
    else $error("add committed to a full queue or with a bad key");
  a_scan_read: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_en && scan_more) |=> rd_valid)
    else $error("scan read not followed by a compare");
`endif

endmodule
